// ----- src/pra_pkg.sv -----
package pra_pkg;

    // Table geometry defaults.
    localparam int NUM_PAGES_DEF  = 1024;
    localparam int PAGE_BYTES_DEF = 128;

    // Field widths of the command and result beats.
    localparam int CMD_W  = 2;
    localparam int REQ_W  = 18;
    localparam int RUN_W  = 10;
    localparam int STAT_W = 2;
    localparam int PAGE_W = 10;
    localparam int OWN_W  = 11;

    // Configuration register.
    localparam int              ACT_W            = 11;
    localparam logic [ACT_W-1:0] ACT_RESET       = 11'd1024;
    localparam int              ACT_MIN          = 2;
    localparam int              APB_ADDR_W       = 3;
    localparam int              APB_DATA_W       = 32;
    localparam logic            REG_ACTIVE_PAGES = 1'b0;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COUNT = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOFIT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [REQ_W-1:0] request_bytes;
        logic [RUN_W-1:0] run_start;
    } pra_in_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PAGE_W-1:0] granted_page;
        logic [OWN_W-1:0]  pages_owned;
    } pra_out_t;

endpackage

// ----- src/pra_ram.sv -----
module pra_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/pra_page_div.sv -----
// Page count for a byte size: the quotient by the page size, rounded up.
// The division is a multiply by a scaled reciprocal of the page size. It is
// exact for every numerator below 2**NUM_W, and the count is registered, ready
// together with done in the cycle after start.
module pra_page_div #(
    parameter int PAGE_BYTES = pra_pkg::PAGE_BYTES_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [pra_pkg::REQ_W-1:0] bytes,
    output logic                    done,
    output logic [pra_pkg::REQ_W-1:0] pages
);

    localparam int     REQ_W  = pra_pkg::REQ_W;
    localparam int     NUM_W  = REQ_W + 1;
    localparam int     SHIFT  = NUM_W + $clog2(PAGE_BYTES);
    localparam int     PROD_W = SHIFT + REQ_W;
    localparam longint RECIP  = ((longint'(1) << SHIFT) + longint'(PAGE_BYTES - 1)) /
                                longint'(PAGE_BYTES);

    logic [NUM_W-1:0]  num;
    logic [PROD_W-1:0] prod;
    logic              done_reg;
    logic [REQ_W-1:0]  pages_reg;

    // Rounding up: one page less a byte is added before the division.
    assign num  = NUM_W'(bytes) + NUM_W'(PAGE_BYTES - 1);
    assign prod = PROD_W'(num) * PROD_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= start;
        end
        if (start) begin
            pages_reg <= prod[SHIFT +: REQ_W];
        end
    end

    assign done  = done_reg;
    assign pages = pages_reg;

endmodule

// ----- src/page_run_allocator_unit.sv -----
// Channel  Dir  Handshake                    Beat contents
// command  in   s_valid, s_ready             s_data: cmd, request_bytes, run_start
// result   out  m_valid, m_ready             m_data: status, granted_page, pages_owned
// config   i/o  psel, penable, pwrite, pready  paddr, pwdata, prdata: active_pages at 0
//
// One command is worked on at a time; the owner table sits in one RAM with a
// registered read and is streamed one page per cycle. An allocate judges pages until a
// free run fits and then tags the pages of that run, a free clears the pages carrying
// its tag, a count reads every active page, and a rejected command goes to finish.
// After reset a clearing pass over all NUM_PAGES pages keeps s_ready low; configuration
// writes are taken throughout. While a result beat waits for m_ready the next command
// beat is still taken, but its own result then waits in the finish state.
module page_run_allocator_unit #(
    parameter int NUM_PAGES  = pra_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BYTES = pra_pkg::PAGE_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  pra_pkg::pra_in_t               s_data,

    output logic                           m_valid,
    input  logic                           m_ready,
    output pra_pkg::pra_out_t              m_data,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pra_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pra_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pra_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    // Page index, page count and the width used for run-end compares.
    localparam int IDX_W = $clog2(NUM_PAGES);
    localparam int CNT_W = $clog2(NUM_PAGES + 1);
    localparam int REQ_W = pra_pkg::REQ_W;
    localparam int ACT_W = pra_pkg::ACT_W;
    localparam int SW    = ((CNT_W > REQ_W) ? CNT_W : REQ_W) + 1;
    localparam int AW    = (CNT_W > ACT_W) ? CNT_W : ACT_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SETUP,
        ST_SCAN,
        ST_TAG,
        ST_FREE,
        ST_COUNT,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [ACT_W-1:0]       active_pages_reg, active_pages_next;
    logic [IDX_W-1:0]       search_start_reg, search_start_next;
    logic [IDX_W-1:0]       start_reg, start_next;
    logic [REQ_W-1:0]       pages_reg, pages_next;
    logic [IDX_W-1:0]       cand_reg, cand_next;
    logic [REQ_W-1:0]       len_reg, len_next;
    logic [IDX_W:0]         issue_reg, issue_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [IDX_W:0]         rd_page_reg, rd_page_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    pra_pkg::pra_out_t      res_reg, res_next;
    logic                   m_valid_reg, m_valid_next;
    pra_pkg::pra_out_t      m_data_reg, m_data_next;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [IDX_W-1:0]       ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [IDX_W-1:0]       ram_rdata;

    logic                   div_start;
    logic                   div_done;
    logic [REQ_W-1:0]       div_pages;

    logic                   cfg_we;
    logic [AW-1:0]          act_ext;
    logic [SW-1:0]          p_eff;
    logic [SW-1:0]          run_ext;
    logic [IDX_W-1:0]       ss_base;
    logic [SW-1:0]          cand_try;

    // ------------------------------------------------------------------
    // Configuration port. The register is written in the access phase of
    // an APB write; reads return the register zero-extended.
    // ------------------------------------------------------------------
    assign cfg_we = psel && penable && pwrite && (paddr[2] == pra_pkg::REG_ACTIVE_PAGES);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == pra_pkg::REG_ACTIVE_PAGES) ?
                    pra_pkg::APB_DATA_W'(active_pages_reg) : '0;

    // The number of pages in use is clamped to the table size, and never
    // below two, since page 0 is reserved.
    assign act_ext = AW'(active_pages_reg);
    always_comb begin
        if (act_ext < AW'(pra_pkg::ACT_MIN)) begin
            p_eff = SW'(pra_pkg::ACT_MIN);
        end else if (act_ext > AW'(NUM_PAGES)) begin
            p_eff = SW'(NUM_PAGES);
        end else begin
            p_eff = SW'(act_ext);
        end
    end

    assign run_ext = SW'(s_data.run_start);

    // Roving pointer goes back to page 1 if the requested run could not
    // fit between it and the end of the active pages.
    assign ss_base = ((search_start_reg == '0) ||
                      (SW'(search_start_reg) + SW'(pages_reg) > p_eff)) ?
                     IDX_W'(1) : search_start_reg;

    // Start of the next candidate run when the page just read is taken.
    assign cand_try = SW'(rd_page_reg) + SW'(1);

    // ------------------------------------------------------------------
    // Owner table: one tag per page, 0 meaning free.
    // ------------------------------------------------------------------
    pra_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_PAGES)
    ) u_owner_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pra_page_div #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_page_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .bytes   (s_data.request_bytes),
        .done    (div_done),
        .pages   (div_pages)
    );

    // ------------------------------------------------------------------
    // Sequencer. Scans issue one read per cycle from issue_reg; the data
    // for the page in rd_page_reg arrives in the cycle after its read and is judged
    // while the next read is already on its way. Reads past the point
    // where a scan stops are simply dropped.
    // ------------------------------------------------------------------
    always_comb begin
        state_next        = state_reg;
        active_pages_next = cfg_we ? pwdata[ACT_W-1:0] : active_pages_reg;
        search_start_next = search_start_reg;
        start_next        = start_reg;
        pages_next        = pages_reg;
        cand_next         = cand_reg;
        len_next          = len_reg;
        issue_next        = issue_reg;
        rd_vld_next       = rd_vld_reg;
        rd_page_next      = rd_page_reg;
        cnt_next          = cnt_reg;
        res_next          = res_reg;
        m_valid_next      = m_valid_reg;
        m_data_next       = m_data_reg;

        ram_we    = 1'b0;
        ram_waddr = issue_reg[IDX_W-1:0];
        ram_wdata = '0;
        ram_raddr = issue_reg[IDX_W-1:0];
        div_start = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            // Zero every tag after reset, one page per cycle.
            ST_CLEAR: begin
                ram_we     = 1'b1;
                issue_next = issue_reg + (IDX_W+1)'(1);
                if (issue_reg == (IDX_W+1)'(NUM_PAGES - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_valid) begin
                    rd_vld_next = 1'b0;
                    cnt_next    = '0;
                    start_next  = IDX_W'(s_data.run_start);
                    case (s_data.cmd)
                        pra_pkg::CMD_ALLOC: begin
                            if (s_data.request_bytes == '0) begin
                                res_next   = '{status: pra_pkg::STAT_BAD,
                                               granted_page: '0, pages_owned: '0};
                                state_next = ST_FINISH;
                            end else begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        pra_pkg::CMD_FREE, pra_pkg::CMD_COUNT: begin
                            if ((run_ext == '0) || (run_ext >= p_eff)) begin
                                res_next   = '{status: pra_pkg::STAT_BAD,
                                               granted_page: '0, pages_owned: '0};
                                state_next = ST_FINISH;
                            end else if (s_data.cmd == pra_pkg::CMD_FREE) begin
                                // The pointer moves even if nothing is cleared.
                                search_start_next = IDX_W'(s_data.run_start);
                                issue_next        = (IDX_W+1)'(s_data.run_start);
                                state_next        = ST_FREE;
                            end else begin
                                issue_next = (IDX_W+1)'(1);
                                state_next = ST_COUNT;
                            end
                        end
                        default: begin
                            res_next   = '{status: pra_pkg::STAT_BAD,
                                           granted_page: '0, pages_owned: '0};
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_DIV: begin
                if (div_done) begin
                    pages_next = div_pages;
                    state_next = ST_SETUP;
                end
            end

            // Apply the wrap of the roving pointer and start the first fit.
            ST_SETUP: begin
                search_start_next = ss_base;
                cand_next         = ss_base;
                issue_next        = {1'b0, ss_base};
                len_next          = '0;
                rd_vld_next       = 1'b0;
                if (SW'(ss_base) + SW'(pages_reg) > p_eff) begin
                    res_next   = '{status: pra_pkg::STAT_NOFIT,
                                   granted_page: '0, pages_owned: '0};
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_SCAN;
                end
            end

            // Track the current free run; a taken page restarts it just past
            // that page. The search ends when the run is long enough, or once no run can fit.
            ST_SCAN: begin
                issue_next   = issue_reg + (IDX_W+1)'(1);
                rd_vld_next  = 1'b1;
                rd_page_next = issue_reg;
                if (rd_vld_reg) begin
                    if (ram_rdata == '0) begin
                        if (len_reg == pages_reg - REQ_W'(1)) begin
                            search_start_next = cand_reg;
                            issue_next        = {1'b0, cand_reg};
                            len_next          = '0;
                            state_next        = ST_TAG;
                        end else begin
                            len_next = len_reg + REQ_W'(1);
                        end
                    end else if (cand_try + SW'(pages_reg) > p_eff) begin
                        res_next   = '{status: pra_pkg::STAT_NOFIT,
                                       granted_page: '0, pages_owned: '0};
                        state_next = ST_FINISH;
                    end else begin
                        cand_next = IDX_W'(cand_try);
                        len_next  = '0;
                    end
                end
            end

            // Write the run's start page into every page of the run.
            ST_TAG: begin
                ram_we     = 1'b1;
                ram_wdata  = cand_reg;
                issue_next = issue_reg + (IDX_W+1)'(1);
                if (len_reg == pages_reg - REQ_W'(1)) begin
                    res_next   = '{status: pra_pkg::STAT_DONE,
                                   granted_page: pra_pkg::PAGE_W'(cand_reg),
                                   pages_owned: pra_pkg::OWN_W'(pages_reg)};
                    state_next = ST_FINISH;
                end else begin
                    len_next = len_reg + REQ_W'(1);
                end
            end

            // Clear consecutive pages that carry the run's tag. The write
            // goes to the page just judged, never to the one being read.
            ST_FREE: begin
                issue_next   = issue_reg + (IDX_W+1)'(1);
                rd_vld_next  = 1'b1;
                rd_page_next = issue_reg;
                if (rd_vld_reg) begin
                    if ((SW'(rd_page_reg) < p_eff) && (ram_rdata == start_reg)) begin
                        ram_we    = 1'b1;
                        ram_waddr = rd_page_reg[IDX_W-1:0];
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end else begin
                        res_next   = '{status: pra_pkg::STAT_DONE, granted_page: '0,
                                       pages_owned: pra_pkg::OWN_W'(cnt_reg)};
                        state_next = ST_FINISH;
                    end
                end
            end

            // Count every active page that carries the tag.
            ST_COUNT: begin
                issue_next   = issue_reg + (IDX_W+1)'(1);
                rd_vld_next  = 1'b1;
                rd_page_next = issue_reg;
                if (rd_vld_reg) begin
                    if (SW'(rd_page_reg) < p_eff) begin
                        if (ram_rdata == start_reg) begin
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end else begin
                        res_next   = '{status: pra_pkg::STAT_DONE, granted_page: '0,
                                       pages_owned: pra_pkg::OWN_W'(cnt_reg)};
                        state_next = ST_FINISH;
                    end
                end
            end

            // Hand the result to the output register once it is free.
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            active_pages_reg <= pra_pkg::ACT_RESET;
            search_start_reg <= IDX_W'(1);
            issue_reg        <= '0;
            rd_vld_reg       <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            active_pages_reg <= active_pages_next;
            search_start_reg <= search_start_next;
            issue_reg        <= issue_next;
            rd_vld_reg       <= rd_vld_next;
            m_valid_reg      <= m_valid_next;
        end
        start_reg   <= start_next;
        pages_reg   <= pages_next;
        cand_reg    <= cand_next;
        len_reg     <= len_next;
        rd_page_reg <= rd_page_next;
        cnt_reg     <= cnt_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------

    // The table is only written by the clear pass, tagging and freeing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE || state_reg == ST_FINISH || state_reg == ST_SCAN ||
         state_reg == ST_COUNT) |-> !ram_we)
        else $error("owner table written outside a writing phase");

    // A failed command reports no page and no count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != pra_pkg::STAT_DONE) |->
        (m_data.granted_page == '0 && m_data.pages_owned == '0))
        else $error("failed result carries a page or a count");

    // The roving pointer never lands on the reserved page.
    assert property (@(posedge aclk) disable iff (!aresetn)
        search_start_reg != '0)
        else $error("roving pointer on reserved page");

    // While searching, the free run seen so far is shorter than the request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (len_reg < pages_reg))
        else $error("free run length reached request without tagging");

endmodule

// ----- tb/sv/page_run_allocator_unit_tb.sv -----
`timescale 1ns / 1ps

module page_run_allocator_unit_tb;

    localparam int CMD_W          = pra_pkg::CMD_W;
    localparam int REQ_W          = pra_pkg::REQ_W;
    localparam int RUN_W          = pra_pkg::RUN_W;
    localparam int PAGE_W         = pra_pkg::PAGE_W;
    localparam int OWN_W          = pra_pkg::OWN_W;
    localparam int ACT_W          = pra_pkg::ACT_W;
    localparam int APB_ADDR_W     = pra_pkg::APB_ADDR_W;
    localparam int APB_DATA_W     = pra_pkg::APB_DATA_W;
    localparam int NUM_PAGES_DEF  = pra_pkg::NUM_PAGES_DEF;
    localparam int PAGE_BYTES_DEF = pra_pkg::PAGE_BYTES_DEF;

    // Command code 3 has no meaning. The block must reject it with a bad status.
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    // Longest job is an allocate that scans and tags the whole table. Nothing may
    // show up after the last reply for at least that long.
    localparam int unsigned TAIL_CYCLES = 2200;

    // Shadow of the allocator: owner tags, the roving search pointer and the
    // active page register. Every accepted command beat is replayed here. The
    // reply the block owes for it is queued until the real reply beat arrives.
    class run_ledger;
        logic [PAGE_W-1:0]  owner [NUM_PAGES_DEF];
        int unsigned        roving;
        logic [ACT_W-1:0]   active_reg;
        pra_pkg::pra_out_t  owed_replies [$];
        int unsigned        live_starts [$];
        int unsigned        errors;

        function new();
            foreach (owner[k]) owner[k] = '0;
            roving     = 1;
            active_reg = pra_pkg::ACT_RESET;
            errors     = 0;
        endfunction

        function void set_active(logic [ACT_W-1:0] v);
            active_reg = v;
        endfunction

        function int unsigned usable_pages();
            int unsigned p;
            p = active_reg;
            if (p < pra_pkg::ACT_MIN) p = pra_pkg::ACT_MIN;
            if (p > NUM_PAGES_DEF) p = NUM_PAGES_DEF;
            return p;
        endfunction

        function void drop_live(int unsigned s);
            for (int k = live_starts.size() - 1; k >= 0; k--) begin
                if (live_starts[k] == s) live_starts.delete(k);
            end
        endfunction

        // Works out the reply for one accepted command and updates the shadow.
        function void take_cmd(pra_pkg::pra_in_t c);
            pra_pkg::pra_out_t r;
            int unsigned       p, pages, i, j, n, cnt, s;
            bit                found;
            r     = '0;
            p     = usable_pages();
            s     = c.run_start;
            found = 0;
            case (c.cmd)
                pra_pkg::CMD_ALLOC: begin
                    if (c.request_bytes == 0) begin
                        r.status = pra_pkg::STAT_BAD;
                    end else begin
                        pages = 1 + (int'(c.request_bytes) - 1) / PAGE_BYTES_DEF;
                        // The pointer wraps to page 1 before the search if the run
                        // cannot fit above it. The search never makes a second pass.
                        if (roving < 1 || roving + pages > p) roving = 1;
                        i = roving;
                        while (!found && i + pages <= p) begin
                            if (owner[i] == 0) begin
                                j = 0;
                                while (j < pages && owner[i + j] == 0) j++;
                                if (j < pages) begin
                                    i = i + j + 1;
                                end else begin
                                    for (j = 0; j < pages; j++) owner[i + j] = PAGE_W'(i);
                                    roving = i;
                                    found  = 1;
                                end
                            end else begin
                                i++;
                            end
                        end
                        if (found) begin
                            r.status       = pra_pkg::STAT_DONE;
                            r.granted_page = PAGE_W'(i);
                            r.pages_owned  = OWN_W'(pages);
                            live_starts.push_back(i);
                        end else begin
                            r.status = pra_pkg::STAT_NOFIT;
                        end
                    end
                end
                pra_pkg::CMD_FREE: begin
                    if (s == 0 || s >= p) begin
                        r.status = pra_pkg::STAT_BAD;
                    end else begin
                        // The pointer moves even when nothing is tagged there.
                        roving = s;
                        n      = s;
                        cnt    = 0;
                        while (n < p && owner[n] == s) begin
                            owner[n] = '0;
                            n++;
                            cnt++;
                        end
                        if (cnt != 0) drop_live(s);
                        r.status      = pra_pkg::STAT_DONE;
                        r.pages_owned = OWN_W'(cnt);
                    end
                end
                pra_pkg::CMD_COUNT: begin
                    if (s == 0 || s >= p) begin
                        r.status = pra_pkg::STAT_BAD;
                    end else begin
                        cnt = 0;
                        for (i = 1; i < p; i++) if (owner[i] == s) cnt++;
                        r.status      = pra_pkg::STAT_DONE;
                        r.pages_owned = OWN_W'(cnt);
                    end
                end
                default: r.status = pra_pkg::STAT_BAD;
            endcase
            owed_replies.push_back(r);
        endfunction

        // Compares one reply beat with the oldest outstanding prediction.
        function void match_reply(pra_pkg::pra_out_t got);
            pra_pkg::pra_out_t want;
            if (owed_replies.size() == 0) begin
                $error("reply beat with no command outstanding: %h", got);
                errors++;
                return;
            end
            want = owed_replies.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.granted_page !== want.granted_page) begin
                $error("granted_page: expected %0d, got %0d",
                       want.granted_page, got.granted_page);
                errors++;
            end
            if (got.pages_owned !== want.pages_owned) begin
                $error("pages_owned: expected %0d, got %0d",
                       want.pages_owned, got.pages_owned);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    pra_pkg::pra_in_t      s_data;
    logic                  m_valid;
    logic                  m_ready;
    pra_pkg::pra_out_t     m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    run_ledger ledger = new();

    // When calm is set, neither side inserts gaps. This gives stretches of
    // back-to-back traffic.
    bit calm;

    page_run_allocator_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Every input has a known value before the first edge.
    initial begin
        aclk    = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
    end

    always #2 aclk = ~aclk;

    // Gap lengths: most are zero or short, some are medium and a few are long.
    function automatic int unsigned pause_len();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic pra_pkg::pra_in_t make_cmd(logic [CMD_W-1:0] c,
                                                  logic [REQ_W-1:0] b,
                                                  logic [RUN_W-1:0] s);
        pra_pkg::pra_in_t v;
        v.cmd           = c;
        v.request_bytes = b;
        v.run_start     = s;
        return v;
    endfunction

    // Result side. Open windows of random length alternate with stalls, and
    // m_ready changes only on the falling edge.
    initial begin
        int unsigned open_len, shut_len;
        forever begin
            open_len = $urandom_range(1, 20);
            @(negedge aclk) m_ready <= 1'b1;
            repeat (open_len - 1) @(negedge aclk);
            shut_len = pause_len();
            if (shut_len > 0) begin
                @(negedge aclk) m_ready <= 1'b0;
                repeat (shut_len - 1) @(negedge aclk);
            end
        end
    end

    // Reply beats are taken at the rising edge on which valid and ready are both high.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) ledger.match_reply(m_data);
    end

    // Sends one command beat after an optional gap. The beat is held until it
    // is accepted, and then handed to the shadow model.
    task automatic push_cmd(input pra_pkg::pra_in_t c);
        int unsigned gap;
        gap = pause_len();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!s_ready);
        ledger.take_cmd(c);
    endtask

    // Lowers valid, then waits until every reply has come back plus a settle time.
    task automatic wait_quiet(input int unsigned settle);
        @(negedge aclk) s_valid <= 1'b0;
        while (ledger.owed_replies.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // Register write. A setup phase is followed by an access phase, and the
    // register takes the value on the edge where pready is seen high.
    task automatic write_active(input logic [ACT_W-1:0] v);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * pra_pkg::REG_ACTIVE_PAGES);
        pwdata  <= APB_DATA_W'(v);
        @(negedge aclk) penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        ledger.set_active(v);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Picks a run start for free or count. Usually this is a run that is
    // really allocated. Sometimes it is the page right after a run start,
    // which is often inside the run. Otherwise it is any page, including
    // page 0 and pages beyond the active range.
    function automatic logic [RUN_W-1:0] pick_start();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (ledger.live_starts.size() != 0 && r < 80) begin
            if (r < 70)
                return RUN_W'(ledger.live_starts[$urandom_range(0,
                              ledger.live_starts.size() - 1)]);
            return RUN_W'(ledger.live_starts[$urandom_range(0,
                          ledger.live_starts.size() - 1)] + 1);
        end
        return RUN_W'($urandom_range(0, 1023));
    endfunction

    // Random commands. Most allocations are a few pages. Page-size edges,
    // zero, huge and unreachable sizes are mixed in. Frees and counts mostly
    // target live runs. Fields the command ignores carry random noise.
    function automatic pra_pkg::pra_in_t draw_cmd();
        int unsigned       r, rb;
        logic [REQ_W-1:0]  bytes;
        logic [REQ_W-1:0]  junk_bytes;
        logic [RUN_W-1:0]  junk_start;
        junk_bytes = REQ_W'($urandom_range(0, (1 << REQ_W) - 1));
        junk_start = RUN_W'($urandom_range(0, 1023));
        r = $urandom_range(0, 99);
        if (r < 45) begin
            rb = $urandom_range(0, 99);
            if (rb < 75)      bytes = REQ_W'($urandom_range(1, 8 * PAGE_BYTES_DEF));
            else if (rb < 85) bytes = REQ_W'(PAGE_BYTES_DEF * $urandom_range(1, 16)
                                             + $urandom_range(0, 2) - 1);
            else if (rb < 92) bytes = REQ_W'($urandom_range(0, (1 << REQ_W) - 1));
            else if (rb < 96) bytes = '0;
            else              bytes = REQ_W'($urandom_range(1024, 16384));
            return make_cmd(pra_pkg::CMD_ALLOC, bytes, junk_start);
        end
        if (r < 75) return make_cmd(pra_pkg::CMD_FREE, junk_bytes, pick_start());
        if (r < 95) return make_cmd(pra_pkg::CMD_COUNT, junk_bytes, pick_start());
        return make_cmd(CMD_UNKNOWN, junk_bytes, junk_start);
    endfunction

    task automatic run_random(input int unsigned n);
        repeat (n) push_cmd(draw_cmd());
    endtask

    // Directed opening on the reset setting of 1024 pages. The beats cover a
    // zero size, page-size edges, sizes that cannot fit, bad pages, freeing a
    // missing run (which still moves the pointer, so the last page gets used),
    // the pointer wrap, freeing inside a run, an unknown command with every
    // bit set, one run that fills the whole table, and an allocate on a full
    // table.
    task automatic run_directed();
        push_cmd(make_cmd(pra_pkg::CMD_ALLOC, '0, '0));
        push_cmd(make_cmd(pra_pkg::CMD_ALLOC, 18'd1, '0));
        push_cmd(make_cmd(pra_pkg::CMD_ALLOC, 18'd128, '0));
        push_cmd(make_cmd(pra_pkg::CMD_ALLOC, 18'd129, '0));
        push_cmd(make_cmd(pra_pkg::CMD_ALLOC, 18'd131072, '0));
        push_cmd(make_cmd(pra_pkg::CMD_ALLOC, '1, '0));
        push_cmd(make_cmd(pra_pkg::CMD_COUNT, '0, 10'd3));
        push_cmd(make_cmd(pra_pkg::CMD_COUNT, '0, 10'd0));
        push_cmd(make_cmd(pra_pkg::CMD_COUNT, '0, 10'd1023));
        push_cmd(make_cmd(pra_pkg::CMD_FREE, '0, 10'd0));
        push_cmd(make_cmd(pra_pkg::CMD_FREE, '0, 10'd1023));
        push_cmd(make_cmd(pra_pkg::CMD_ALLOC, 18'd1, '0));
        push_cmd(make_cmd(pra_pkg::CMD_ALLOC, 18'd256, '0));
        push_cmd(make_cmd(pra_pkg::CMD_FREE, '0, 10'd4));
        push_cmd(make_cmd(pra_pkg::CMD_FREE, '0, 10'd3));
        push_cmd(make_cmd(pra_pkg::CMD_FREE, '0, 10'd3));
        push_cmd('1);
        while (ledger.live_starts.size() != 0)
            push_cmd(make_cmd(pra_pkg::CMD_FREE, '0, RUN_W'(ledger.live_starts[0])));
        push_cmd(make_cmd(pra_pkg::CMD_ALLOC, 18'd130944, '0));
        push_cmd(make_cmd(pra_pkg::CMD_COUNT, '0, 10'd1));
        push_cmd(make_cmd(pra_pkg::CMD_ALLOC, 18'd1, '0));
        push_cmd(make_cmd(pra_pkg::CMD_FREE, '0, 10'd1));
    endtask

    // Main sequence. Reset is applied once. The directed and random traffic
    // first runs on the reset setting. After that, each phase writes a new
    // active page count while the block is idle. The counts include values
    // below the minimum, above the table size, tiny tables and the full table.
    // Tags left above a shrunken range carry over into later phases.
    initial begin
        logic [ACT_W-1:0] settings [8];
        settings = '{11'd64, 11'd0, 11'd3, 11'd2047, 11'd1, 11'd300, 11'd2, 11'd1024};
        calm = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        run_directed();
        run_random(220);
        foreach (settings[ph]) begin
            wait_quiet(8);
            write_active(settings[ph]);
            calm = (ph % 3 == 2);
            run_random(190);
        end
        wait_quiet(TAIL_CYCLES);
        if (ledger.errors == 0) begin
            $display("page_run_allocator_unit_tb passed");
        end else begin
            $display("page_run_allocator_unit_tb failed");
        end
        $finish;
    end

    // Watchdog. A correct run finishes far sooner than this.
    initial begin
        #(100_000_000);
        $display("page_run_allocator_unit_tb failed");
        $finish;
    end

endmodule

// ----- page_run_allocator_unit.f -----
src/pra_pkg.sv
src/pra_ram.sv
src/pra_page_div.sv
src/page_run_allocator_unit.sv
tb/sv/page_run_allocator_unit_tb.sv
